// ===== hdl/pvtb_pkg.sv =====
// shared types and constants for the periodic virtual timer bank
package pvtb_pkg;

    localparam int NUM_TIMERS = 10;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int FIRED_W    = 10;
    localparam int MS_W       = 32;

    localparam logic [MS_W-1:0] MAX_DURATION_RESET = 32'd1000000000;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_RESET = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ID   = 2'd1,
        ST_IN_USE   = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        US_OFF  = 2'd0,
        US_BUSY = 2'd1,
        US_DONE = 2'd2
    } t_user;

    typedef enum logic [1:0] {
        QA_BUSY = 2'd0,
        QA_DONE = 2'd1,
        QA_IDLE = 2'd2
    } t_answer;

    typedef struct packed {
        logic             we_exp;
        logic             we_per;
        logic [IDX_W-1:0] addr;
        logic [MS_W-1:0]  exp;
        logic [MS_W-1:0]  per;
    } t_store_wr;

endpackage

// ===== hdl/periodic_virtual_timer_bank.sv =====
// top level of the periodic virtual timer bank
//
// input channel: i_in_valid / o_in_stall carries one word of action, timer id
// and duration. output channel: o_out_valid / i_out_stall returns one word per
// input word with status, query answer, fired mask and the millisecond count.
// config channel: i_cfg_valid / o_cfg_ready writes max_duration, always ready.
//
// a tick walks the timers one per cycle through a single compare-and-add
// unit reading the expiry/period memory: setup in S_EXEC, the walk over the
// timers in S_WALK, then the result load in S_DONE. start, query and reset
// go from S_EXEC straight to the result load in S_DONE. one word is in work
// at a time; o_in_stall is high from accept until the result is loaded into
// the output register.
//
// a result waits in the output register while i_out_stall is high, and the
// next word may be accepted meanwhile; its result is held back until the
// register is free. synchronous reset clears the count, all timers to off,
// max_duration to 1000000000, and drops o_out_valid.
module periodic_virtual_timer_bank (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_timer_id,
    input  logic [31:0] i_duration,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [1:0]  o_query_answer,
    output logic [9:0]  o_fired_mask,
    output logic [31:0] o_now_ms,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DONE
    } t_state;

    t_state                             r_state;
    pvtb_pkg::t_action                  r_act;
    logic [3:0]                         r_id;
    logic [pvtb_pkg::MS_W-1:0]          r_dur;
    logic [pvtb_pkg::MS_W-1:0]          r_max_dur;
    logic [pvtb_pkg::MS_W-1:0]          r_count;
    logic [pvtb_pkg::IDX_W-1:0]         r_k;
    logic [pvtb_pkg::FIRED_W-1:0]       r_fired;
    pvtb_pkg::t_status                  r_res_status;
    pvtb_pkg::t_answer                  r_res_answer;
    logic                               r_active [pvtb_pkg::NUM_TIMERS];
    pvtb_pkg::t_user                    r_user   [pvtb_pkg::NUM_TIMERS];
    logic                               r_out_valid;
    pvtb_pkg::t_status                  r_out_status;
    pvtb_pkg::t_answer                  r_out_answer;
    logic [pvtb_pkg::FIRED_W-1:0]       r_out_fired;
    logic [pvtb_pkg::MS_W-1:0]          r_out_now;

    logic [pvtb_pkg::IDX_W-1:0]         id_idx;
    logic                               id_bad;
    logic                               k_last;
    logic                               k_fire;
    logic                               start_ok;
    logic                               out_free;
    pvtb_pkg::t_status                  exec_status;
    pvtb_pkg::t_answer                  exec_answer;
    logic [pvtb_pkg::IDX_W-1:0]         rd_addr;
    logic [pvtb_pkg::MS_W-1:0]          rd_exp;
    logic [pvtb_pkg::MS_W-1:0]          rd_per;
    pvtb_pkg::t_store_wr                store_wr;

    always_comb begin
        id_idx   = pvtb_pkg::IDX_W'(r_id);
        id_bad   = (32'(r_id) >= 32'(pvtb_pkg::NUM_TIMERS));
        k_last   = (r_k == pvtb_pkg::IDX_W'(pvtb_pkg::NUM_TIMERS - 1));
        k_fire   = r_active[r_k] && !(rd_exp > r_count);
        start_ok = (r_act == pvtb_pkg::ACT_START) && !id_bad && !r_active[id_idx]
                   && !(r_dur > r_max_dur);
        out_free = !r_out_valid || !i_out_stall;
        exec_status = pvtb_pkg::ST_OK;
        exec_answer = pvtb_pkg::QA_BUSY;
        if (r_act != pvtb_pkg::ACT_TICK) begin
            if (id_bad) begin
                exec_status = pvtb_pkg::ST_BAD_ID;
            end else if (r_act == pvtb_pkg::ACT_START) begin
                if (r_active[id_idx]) begin
                    exec_status = pvtb_pkg::ST_IN_USE;
                end else if (!start_ok) begin
                    exec_status = pvtb_pkg::ST_TOO_LONG;
                end
            end else if (r_act == pvtb_pkg::ACT_QUERY) begin
                if (r_user[id_idx] == pvtb_pkg::US_BUSY) begin
                    exec_answer = pvtb_pkg::QA_BUSY;
                end else if (r_user[id_idx] == pvtb_pkg::US_DONE) begin
                    exec_answer = pvtb_pkg::QA_DONE;
                end else begin
                    exec_answer = pvtb_pkg::QA_IDLE;
                end
            end
        end
        if (r_state == S_EXEC || k_last) begin
            rd_addr = (r_state == S_EXEC) ? '0 : r_k;
        end else begin
            rd_addr = pvtb_pkg::IDX_W'(r_k + 1'b1);
        end
        store_wr = '0;
        if (r_state == S_EXEC && start_ok) begin
            store_wr.we_exp = 1'b1;
            store_wr.we_per = 1'b1;
            store_wr.addr   = id_idx;
            store_wr.exp    = r_count + r_dur;
            store_wr.per    = r_dur;
        end else if (r_state == S_WALK && k_fire) begin
            store_wr.we_exp = 1'b1;
            store_wr.addr   = r_k;
            store_wr.exp    = rd_exp + rd_per;
        end
    end

    pvtb_timer_store u_store (
        .i_clk     (i_clk),
        .i_wr      (store_wr),
        .i_rd_addr (rd_addr),
        .o_rd_exp  (rd_exp),
        .o_rd_per  (rd_per)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_dur   <= pvtb_pkg::MAX_DURATION_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < pvtb_pkg::NUM_TIMERS; i++) begin
                r_active[i] <= 1'b0;
                r_user[i]   <= pvtb_pkg::US_OFF;
            end
        end else begin
            if (i_cfg_valid) begin
                r_max_dur <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act   <= pvtb_pkg::t_action'(i_action);
                        r_id    <= i_timer_id;
                        r_dur   <= i_duration;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_status <= exec_status;
                    r_res_answer <= exec_answer;
                    r_fired      <= '0;
                    r_k          <= '0;
                    if (r_act == pvtb_pkg::ACT_TICK) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_WALK;
                    end else begin
                        r_state <= S_DONE;
                        if (!id_bad) begin
                            unique case (r_act)
                                pvtb_pkg::ACT_START: begin
                                    if (start_ok) begin
                                        r_active[id_idx] <= 1'b1;
                                        r_user[id_idx]   <= pvtb_pkg::US_BUSY;
                                    end
                                end
                                pvtb_pkg::ACT_QUERY: begin
                                    if (r_user[id_idx] == pvtb_pkg::US_DONE) begin
                                        r_user[id_idx] <= pvtb_pkg::US_BUSY;
                                    end
                                end
                                default: begin
                                    r_active[id_idx] <= 1'b0;
                                    r_user[id_idx]   <= pvtb_pkg::US_OFF;
                                end
                            endcase
                        end
                    end
                end
                S_WALK: begin
                    if (k_fire) begin
                        r_user[r_k] <= pvtb_pkg::US_DONE;
                        r_fired     <= r_fired | (pvtb_pkg::FIRED_W'(1) << r_k);
                    end
                    if (k_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k <= pvtb_pkg::IDX_W'(r_k + 1'b1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_status <= r_res_status;
                        r_out_answer <= r_res_answer;
                        r_out_fired  <= r_fired;
                        r_out_now    <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_query_answer = r_out_answer;
    assign o_fired_mask   = r_out_fired;
    assign o_now_ms       = r_out_now;

endmodule

// ===== hdl/pvtb_timer_store.sv =====
// expiry and period memory with one write port and one registered read port
module pvtb_timer_store (
    input  logic                        i_clk,
    input  pvtb_pkg::t_store_wr         i_wr,
    input  logic [pvtb_pkg::IDX_W-1:0]  i_rd_addr,
    output logic [pvtb_pkg::MS_W-1:0]   o_rd_exp,
    output logic [pvtb_pkg::MS_W-1:0]   o_rd_per
);

    logic [pvtb_pkg::MS_W-1:0] r_exp_mem [pvtb_pkg::NUM_TIMERS];
    logic [pvtb_pkg::MS_W-1:0] r_per_mem [pvtb_pkg::NUM_TIMERS];

    always_ff @(posedge i_clk) begin
        if (i_wr.we_exp) begin
            r_exp_mem[i_wr.addr] <= i_wr.exp;
        end
        if (i_wr.we_per) begin
            r_per_mem[i_wr.addr] <= i_wr.per;
        end
        o_rd_exp <= r_exp_mem[i_rd_addr];
        o_rd_per <= r_per_mem[i_rd_addr];
    end

endmodule

// ===== hdl/pvtb_checker.sv =====
// port-level checks for the periodic virtual timer bank, bound to the top level
module pvtb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [1:0]  o_query_answer,
    input logic [9:0]  o_fired_mask
);

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a held result stays valid
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result dropped");

    // only a tick fires timers, and a tick always reports ok with answer QA_BUSY
    a_fired_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_fired_mask != '0) |->
            (o_status == pvtb_pkg::ST_OK) && (o_query_answer == pvtb_pkg::QA_BUSY))
        else $error("fired mask on a non-tick word");

    // a word accepted now cannot produce its result in the next cycle
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

endmodule

bind periodic_virtual_timer_bank pvtb_checker u_pvtb_checker (.*);
